// ===== design/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Holds the transaction payload types, the command codes and the button count.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Number of buttons that exist, 1 to 8. The payload always has eight slots.
  localparam int NUM_BUTTONS = 8;
  localparam int MAX_BUTTONS = 8;

  // Sample bits that belong to existing buttons.
  localparam logic [MAX_BUTTONS-1:0] BTN_MASK =
    MAX_BUTTONS'((9'd1 << NUM_BUTTONS) - 9'd1);

  typedef logic [2:0]  cmd_t;
  typedef logic [15:0] limit_t;
  typedef logic [31:0] ms_t;

  localparam cmd_t CMD_NONE       = 3'd0;
  localparam cmd_t CMD_PRESS_EDGE = 3'd1;
  localparam cmd_t CMD_HELD       = 3'd2;
  localparam cmd_t CMD_LONG       = 3'd3;
  localparam cmd_t CMD_RELEASE    = 3'd4;

  localparam limit_t LIMIT_RESET = 16'd1000;

  typedef struct packed {
    logic [MAX_BUTTONS-1:0] first_sample;
    logic [MAX_BUTTONS-1:0] second_sample;
    ms_t                    now_ms;
  } in_item_t;

  typedef struct packed {
    logic rejected;
    cmd_t cmd_button0;
    cmd_t cmd_button1;
    cmd_t cmd_button2;
    cmd_t cmd_button3;
    cmd_t cmd_button4;
    cmd_t cmd_button5;
    cmd_t cmd_button6;
    cmd_t cmd_button7;
  } out_item_t;

endpackage

// ===== design/bpc_in_if.sv =====
// ----------------------------------------------------------------------------
// bpc_in_if: sample channel
// Valid/ready channel that carries one pair of button samples and a timestamp.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  import bpc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/bpc_out_if.sv =====
// ----------------------------------------------------------------------------
// bpc_out_if: command channel
// Valid/ready channel that carries the rejection flag and eight commands.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  import bpc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/button_press_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier_core: debounced button classifier with long press
// Two-stage pipeline: an input register, then eight per-button classifiers
// feeding the result register and the per-button state.
// ----------------------------------------------------------------------------
// A transaction passes from the input register to the result register, where
// it is offered until taken. Throughput: one transaction per cycle unless the
// sink stalls; the per-button state is updated by a single pass of the
// classifiers, so each item sees the previous item's state.
// Reset (rst, synchronous, active high) empties both stages, clears levels,
// press times and commands to zero, and loads the long press limit with 1000.
module button_press_classifier_core (
  input  logic            clk,
  input  logic            rst,
  bpc_in_if.sink          samples,
  bpc_out_if.source       result,
  input  logic            cfg_wr_en,
  input  bpc_pkg::limit_t cfg_wr_data
);
  import bpc_pkg::*;

  // Input register stage. It holds a transaction until the result register
  // can take its outcome.
  logic     s1_valid;
  in_item_t s1_item;

  // The stage advances whenever the result register is empty or being drained.
  // Because the classification is a single pass, a new transaction can enter
  // in the same cycle the previous one moves on.
  logic advance;

  // Long press limit; written only while the block is idle, a user duty.
  limit_t long_press_limit;

  // Per-button state: last accepted levels, press times and last commands.
  logic [NUM_BUTTONS-1:0] accepted_levels;
  ms_t                    press_times [NUM_BUTTONS];
  cmd_t                   commands [NUM_BUTTONS];

  // Outcome of the classifiers for the transaction in the input register.
  ms_t                    press_times_next [NUM_BUTTONS];
  cmd_t                   commands_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] levels_now;
  logic                   rejected_now;
  cmd_t                   report [MAX_BUTTONS];
  out_item_t              out_item;

  assign advance       = !result.valid || result.ready;
  assign samples.ready = !s1_valid || advance;

  // Only existing buttons take part in the agreement check.
  assign rejected_now = ((s1_item.first_sample ^ s1_item.second_sample) & BTN_MASK) != '0;
  assign levels_now   = s1_item.first_sample[NUM_BUTTONS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      long_press_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_item <= samples.data;
    end
  end

  // One classifier per existing button. All eight are independent, so the
  // whole transaction settles combinationally.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    bpc_button u_button (
      .was_pressed     (accepted_levels[i]),
      .pressed         (levels_now[i]),
      .now_ms          (s1_item.now_ms),
      .press_time      (press_times[i]),
      .limit           (long_press_limit),
      .cmd             (commands_next[i]),
      .press_time_next (press_times_next[i])
    );
  end

  // A rejected transaction reports the stored commands unchanged; missing
  // buttons always report no command.
  for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_report
    if (i < NUM_BUTTONS) begin : g_used
      assign report[i] = rejected_now ? commands[i] : commands_next[i];
    end else begin : g_unused
      assign report[i] = CMD_NONE;
    end
  end

  always_comb begin
    out_item.rejected    = rejected_now;
    out_item.cmd_button0 = report[0];
    out_item.cmd_button1 = report[1];
    out_item.cmd_button2 = report[2];
    out_item.cmd_button3 = report[3];
    out_item.cmd_button4 = report[4];
    out_item.cmd_button5 = report[5];
    out_item.cmd_button6 = report[6];
    out_item.cmd_button7 = report[7];
  end

  // The state moves forward only when an agreeing transaction leaves the
  // input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_levels <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_times[i] <= '0;
        commands[i]    <= CMD_NONE;
      end
    end else if (s1_valid && advance && !rejected_now) begin
      accepted_levels <= levels_now;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_times[i] <= press_times_next[i];
        commands[i]    <= commands_next[i];
      end
    end
  end

  // Result register: it keeps its transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result.data <= out_item;
    end
  end

endmodule

// ===== design/bpc_button.sv =====
// ----------------------------------------------------------------------------
// bpc_button: per-button classifier
// Classifies one button against its last accepted level and updates its
// recorded press time.
// ----------------------------------------------------------------------------
module bpc_button (
  input  logic            was_pressed,
  input  logic            pressed,
  input  bpc_pkg::ms_t    now_ms,
  input  bpc_pkg::ms_t    press_time,
  input  bpc_pkg::limit_t limit,
  output bpc_pkg::cmd_t   cmd,
  output bpc_pkg::ms_t    press_time_next
);
  import bpc_pkg::*;

  ms_t elapsed;

  // Elapsed time wraps naturally in 32 bits.
  assign elapsed = now_ms - press_time;

  always_comb begin
    cmd             = CMD_NONE;
    press_time_next = press_time;
    unique case ({was_pressed, pressed})
      2'b00: begin
        cmd = CMD_NONE;
      end
      2'b01: begin
        cmd             = CMD_PRESS_EDGE;
        press_time_next = now_ms;
      end
      2'b11: begin
        cmd = (elapsed >= {16'd0, limit}) ? CMD_LONG : CMD_HELD;
      end
      default: begin
        cmd             = CMD_RELEASE;
        press_time_next = '0;
      end
    endcase
  end

endmodule

// ===== design/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks of the button press classifier
// Watches the channels of the core and is bound to its top level.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bpc_pkg::out_item_t out_data
);
  import bpc_pkg::*;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An accepted transaction moves from the input register to the result
  // register when the sink is ready while it waits in the input register.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("accepted transaction did not produce a result");

  // Every command is a defined code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cmd_button0 <= CMD_RELEASE && out_data.cmd_button1 <= CMD_RELEASE
      && out_data.cmd_button2 <= CMD_RELEASE && out_data.cmd_button3 <= CMD_RELEASE
      && out_data.cmd_button4 <= CMD_RELEASE && out_data.cmd_button5 <= CMD_RELEASE
      && out_data.cmd_button6 <= CMD_RELEASE && out_data.cmd_button7 <= CMD_RELEASE)
    else $error("undefined command code in result");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

// ===== tb/tb_button_press_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier_core: self-checking bench for the button classifier
// A directed table covers reset, rejection, edges, long holds and time wrap.
// Random phases follow, each at its own long press limit. A local model of the
// per-button state predicts every result, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_core;
  import bpc_pkg::*;

  // Cycles to let pass after the last result before the limit is rewritten or
  // the run ends.
  localparam int SETTLE_CYCLES = 4;
  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  localparam int PHASE_ITEMS = 90;
  localparam int NUM_PHASES = 5;
  localparam int NUM_ROWS = 20;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_e;

  // One row of the directed table. Rows marked as typed carry their expected
  // result directly: a rejection flag and one command shared by all buttons.
  typedef struct packed {
    row_kind_e kind;
    limit_t    limit;
    logic [7:0] first;
    logic [7:0] second;
    ms_t       now_ms;
    logic      typed;
    logic      exp_rej;
    cmd_t      exp_cmd;
  } row_t;

  // Result known in advance for a transaction, or a marker to use the model.
  typedef struct packed {
    logic      typed;
    out_item_t value;
  } known_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  limit_t cfg_wr_data = '0;

  bpc_in_if  samples_ch ();
  bpc_out_if result_ch ();

  button_press_classifier_core uut (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Local copy of the core's state, advanced once per accepted transaction.
  limit_t     limit_model = LIMIT_RESET;
  logic [7:0] levels_model = '0;
  ms_t        press_ms [MAX_BUTTONS];
  cmd_t       cmd_model [MAX_BUTTONS];

  out_item_t     pending_commands_q [$];
  known_result_t known_results_q [$];

  int errors = 0;
  int idle_cycles = 0;
  logic drv_burst = 1'b0;
  logic sink_burst = 1'b0;

  wire sample_fire = samples_ch.valid && samples_ch.ready;
  wire result_fire = result_ch.valid && result_ch.ready;

  // Directed table. It walks one story through the state: a rejection shortly
  // after reset, a press of every button, a rejection that must repeat the
  // stored commands, a short hold, a hold that reaches the limit exactly, a
  // partial and a full release. A zero limit then makes any hold long at once.
  // With the largest limit a press just before the time counter wraps is held
  // across the wrap, first one short of the limit and then exactly at it.
  // Disagreements and a full release end the table; the reset limit then returns.
  row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ITEM,  16'd0,     8'h00, 8'h00, 32'd0,         1'b1, 1'b0, CMD_NONE},
    '{ROW_ITEM,  16'd0,     8'hFF, 8'h00, 32'd5,         1'b1, 1'b1, CMD_NONE},
    '{ROW_ITEM,  16'd0,     8'hFF, 8'hFF, 32'd100,       1'b1, 1'b0, CMD_PRESS_EDGE},
    '{ROW_ITEM,  16'd0,     8'h0F, 8'hF0, 32'd200,       1'b1, 1'b1, CMD_PRESS_EDGE},
    '{ROW_ITEM,  16'd0,     8'hFF, 8'hFF, 32'd500,       1'b1, 1'b0, CMD_HELD},
    '{ROW_ITEM,  16'd0,     8'hFF, 8'hFF, 32'd1100,      1'b1, 1'b0, CMD_LONG},
    '{ROW_ITEM,  16'd0,     8'h0F, 8'h0F, 32'd1200,      1'b0, 1'b0, CMD_NONE},
    '{ROW_ITEM,  16'd0,     8'h00, 8'h00, 32'd1300,      1'b0, 1'b0, CMD_NONE},
    '{ROW_LIMIT, 16'd0,     8'h00, 8'h00, 32'd0,         1'b0, 1'b0, CMD_NONE},
    '{ROW_ITEM,  16'd0,     8'h55, 8'h55, 32'hFFFF_FFF0, 1'b0, 1'b0, CMD_NONE},
    '{ROW_ITEM,  16'd0,     8'h55, 8'h55, 32'hFFFF_FFF0, 1'b0, 1'b0, CMD_NONE},
    '{ROW_ITEM,  16'd0,     8'h00, 8'h00, 32'd10,        1'b0, 1'b0, CMD_NONE},
    '{ROW_LIMIT, 16'hFFFF,  8'h00, 8'h00, 32'd0,         1'b0, 1'b0, CMD_NONE},
    '{ROW_ITEM,  16'd0,     8'hFF, 8'hFF, 32'hFFFF_FFF0, 1'b1, 1'b0, CMD_PRESS_EDGE},
    '{ROW_ITEM,  16'd0,     8'hFF, 8'hFF, 32'h0000_FFEE, 1'b1, 1'b0, CMD_HELD},
    '{ROW_ITEM,  16'd0,     8'hFF, 8'hFF, 32'h0000_FFEF, 1'b1, 1'b0, CMD_LONG},
    '{ROW_ITEM,  16'd0,     8'h80, 8'h00, 32'd0,         1'b1, 1'b1, CMD_LONG},
    '{ROW_ITEM,  16'd0,     8'h01, 8'h02, 32'd7,         1'b1, 1'b1, CMD_LONG},
    '{ROW_ITEM,  16'd0,     8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, CMD_RELEASE},
    '{ROW_LIMIT, LIMIT_RESET, 8'h00, 8'h00, 32'd0,       1'b0, 1'b0, CMD_NONE}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      press_ms[i] = '0;
      cmd_model[i] = CMD_NONE;
    end
  end

  // Advances the local state by one sample pair and returns the result the
  // core must report for it. Disagreeing samples leave the state untouched
  // and report the stored commands. Buttons beyond NUM_BUTTONS report none.
  function automatic out_item_t classify_sample_pair(in_item_t item);
    logic [7:0] a;
    logic [7:0] b;
    logic       was_on;
    logic       is_on;
    ms_t        elapsed;
    logic [3*MAX_BUTTONS:0] packed_res;
    a = item.first_sample & BTN_MASK;
    b = item.second_sample & BTN_MASK;
    if (a == b) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        was_on = levels_model[i];
        is_on = a[i];
        if (!was_on && !is_on) begin
          cmd_model[i] = CMD_NONE;
        end else if (!was_on && is_on) begin
          cmd_model[i] = CMD_PRESS_EDGE;
          press_ms[i] = item.now_ms;
        end else if (was_on && is_on) begin
          // Unsigned 32-bit subtraction wraps exactly like the millisecond counter.
          elapsed = item.now_ms - press_ms[i];
          cmd_model[i] = (elapsed >= ms_t'(limit_model)) ? CMD_LONG : CMD_HELD;
        end else begin
          cmd_model[i] = CMD_RELEASE;
          press_ms[i] = '0;
        end
      end
      levels_model = a;
    end
    packed_res[3*MAX_BUTTONS] = (a != b);
    for (int i = 0; i < MAX_BUTTONS; i++)
      packed_res[3*MAX_BUTTONS-1-3*i -: 3] = (i < NUM_BUTTONS) ? cmd_model[i] : CMD_NONE;
    return out_item_t'(packed_res);
  endfunction

  // Offers one transaction on the sample channel after a random gap and
  // returns at the edge where the core takes it. The known result queue is
  // filled before valid rises, so the monitor always finds the matching entry.
  task automatic send_item(input in_item_t item, input logic typed, input out_item_t typed_val);
    int gap;
    gap = drv_burst ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 31) == 0)
      drv_burst = ~drv_burst;
    if (gap != 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    known_results_q.push_back('{typed, typed_val});
    samples_ch.valid <= 1'b1;
    samples_ch.data <= item;
    do @(posedge clk); while (!(samples_ch.valid && samples_ch.ready));
  endtask

  // The limit register is only written once the core has drained: every
  // expected result has come back and the pipeline has had time to settle.
  // It first waits until the monitor has booked the last transaction.
  task automatic set_limit(input limit_t value);
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_commands_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus: reset, the directed table, then random phases, then the drain.
  initial begin
    in_item_t   item;
    logic [7:0] levels;
    logic [7:0] flip;
    ms_t        clock_ms;
    limit_t     phase_limit;
    int         pick;
    samples_ch.valid = 1'b0;
    samples_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_LIMIT) begin
        set_limit(directed_rows[r].limit);
      end else begin
        item = '{directed_rows[r].first, directed_rows[r].second, directed_rows[r].now_ms};
        send_item(item, directed_rows[r].typed,
                  out_item_t'({directed_rows[r].exp_rej, {MAX_BUTTONS{directed_rows[r].exp_cmd}}}));
      end
    end

    // Random phases. Most transactions are clean sample pairs whose levels
    // drift a few bits at a time while the clock moves forward by steps scaled
    // to the limit, so presses grow into holds and long holds and then get
    // released. The rest are disagreeing pairs and fully random noise, and the
    // clock occasionally jumps anywhere so that it also crosses the wrap.
    levels = '0;
    clock_ms = $urandom();
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_limit = limit_t'($urandom_range(1, 3000));
        1: phase_limit = '0;
        2: phase_limit = '1;
        3: phase_limit = limit_t'($urandom_range(0, 65535));
        default: phase_limit = LIMIT_RESET;
      endcase
      set_limit(phase_limit);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0)
          clock_ms = $urandom();
        else
          clock_ms = clock_ms + ms_t'($urandom_range(0, int'(phase_limit) / 4 + 4));
        pick = $urandom_range(0, 99);
        if (pick < 30)
          levels[$urandom_range(0, 7)] ^= 1'b1;
        else if (pick < 40)
          levels ^= 8'($urandom() & $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          item = '{levels, levels, clock_ms};
        end else if (pick < 92) begin
          flip = 8'($urandom_range(1, 255));
          item = $urandom_range(0, 1) ? in_item_t'{levels, levels ^ flip, clock_ms}
                                      : in_item_t'{levels ^ flip, levels, clock_ms};
        end else begin
          item = '{8'($urandom()), 8'($urandom()), clock_ms};
        end
        send_item(item, 1'b0, '0);
      end
    end

    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_commands_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("** button_press_classifier_core: PASSED **");
    else
      $display("** button_press_classifier_core: FAILED **");
    $finish;
  end

  // Result sink: before each transaction it holds ready low for a random
  // number of cycles, with stretches where it takes one result every cycle.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 31) == 0)
        sink_burst = ~sink_burst;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  // Monitor. Both channels and the register port are sampled at the rising
  // edge, before any input driven at that edge takes effect. The result side
  // is handled first: a transaction accepted at this edge cannot have a
  // result at the same edge.
  always @(posedge clk) begin
    out_item_t     want;
    out_item_t     got;
    known_result_t known;
    out_item_t     modeled;
    if (!rst) begin
      if (result_fire) begin
        got = result_ch.data;
        if (pending_commands_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          errors++;
        end else begin
          want = pending_commands_q.pop_front();
          if (got.rejected !== want.rejected) begin
            $display("%0t: rejected expected %0d, got %0d", $time, want.rejected, got.rejected);
            errors++;
          end
          for (int i = 0; i < MAX_BUTTONS; i++) begin
            if (got[3*MAX_BUTTONS-1-3*i -: 3] !== want[3*MAX_BUTTONS-1-3*i -: 3]) begin
              $display("%0t: cmd_button%0d expected %0d, got %0d", $time, i,
                       want[3*MAX_BUTTONS-1-3*i -: 3], got[3*MAX_BUTTONS-1-3*i -: 3]);
              errors++;
            end
          end
        end
      end
      if (sample_fire) begin
        // The model always advances, so typed rows keep it in step too.
        modeled = classify_sample_pair(samples_ch.data);
        known = known_results_q.pop_front();
        pending_commands_q.push_back(known.typed ? known.value : modeled);
      end
      if (cfg_wr_en)
        limit_model = cfg_wr_data;
    end
  end

  // Watchdog: a run where neither channel moves for too long is hung.
  always @(posedge clk) begin
    if (rst || sample_fire || result_fire)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
      $display("** button_press_classifier_core: FAILED **");
      $finish;
    end
  end

endmodule
